/* hdl/lrs_pkg.sv */
// lrs_pkg: shared types and constants of the lazy range add/assign/sum tree
// no dependencies; imported by the interfaces, the node memory, the tag
// multiplier and the top level
package lrs_pkg;

    localparam int SUM_W = 64;
    localparam int VAL_W = 32;
    localparam int POS_W = 10;
    localparam int CNT_W = 11;

    localparam logic [1:0] REQ_QUERY  = 2'd0;
    localparam logic [1:0] REQ_ADD    = 2'd1;
    localparam logic [1:0] REQ_ASSIGN = 2'd2;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    localparam logic [CNT_W-1:0] ELEMENT_COUNT_RESET = 11'd1024;

    // one tree node as held in the node memory
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [SUM_W-1:0] add;
        logic [VAL_W-1:0] asg;
        logic             flag;
    } node_rec_t;

    typedef struct packed {
        logic lo_en;
        logic hi_en;
    } mul_ctl_t;

    // where the walker stands within the work on one node
    typedef enum logic [2:0] {
        PH_COVER   = 3'd0,
        PH_PUSH_A  = 3'd1,
        PH_PUSH_B  = 3'd2,
        PH_CHILD_A = 3'd3,
        PH_CHILD_B = 3'd4,
        PH_DONE    = 3'd5
    } phase_t;

endpackage

/* hdl/lrs_if.sv */
// lrs_if: request and result channels of the range tree
// depends on lrs_pkg for field widths
interface lrs_req_if;
    import lrs_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [1:0]              req_type;
    logic [POS_W-1:0]        range_low;
    logic [POS_W-1:0]        range_high;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output req_type, output range_low,
                    output range_high, output value, input ready);
    modport sink   (input valid, input req_type, input range_low,
                    input range_high, input value, output ready);
endinterface

interface lrs_res_if;
    import lrs_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [SUM_W-1:0] range_sum;
    logic                    status;

    modport source (output valid, output range_sum, output status, input ready);
    modport sink   (input valid, input range_sum, input status, output ready);
endinterface

/* hdl/lazy_range_add_assign_sum_tree.sv */
// Lazy segment tree over LEAVES signed elements: range add, range assign and
// range sum, sums wrapping modulo 2^64. All node state (sum, add tag, assign
// tag) lives in one node memory of 4*LEAVES entries with a registered read;
// a sequencer walks the tree depth first with a small frame stack and does a
// read-modify-write per node. After reset a clearing pass writes zero to all
// 4*LEAVES entries, one per cycle, and no request is taken until it ends.
// One request is worked on at a time. A fully covered node is read; a query
// adds its sum up, an update applies its tag through the tag multiplier and
// writes the node back; then it returns. A split node is read, pushes its tags
// into both children through the tag multiplier, takes three child steps, the
// last writing its sum back, and returns. Rejected requests skip the tree walk.
// Depends on lrs_pkg, lrs_if, lrs_node_mem and lrs_tag_mul.
module lazy_range_add_assign_sum_tree #(
    parameter int LEAVES = 1024
) (
    input  logic                      clk,
    input  logic                      rst_n,
    lrs_req_if.sink                   req,
    lrs_res_if.source                 res,
    input  logic                      cfg_wr_en,
    input  logic [lrs_pkg::CNT_W-1:0] cfg_wr_data
);
    import lrs_pkg::*;

    localparam int NODES = 4 * LEAVES;
    localparam int AW    = $clog2(NODES);
    localparam int LW    = $clog2(LEAVES);
    localparam int PW    = (LW > POS_W) ? LW : POS_W;
    localparam int LEN_W = LW + 1;
    localparam int CW    = (LEN_W > CNT_W) ? LEN_W : CNT_W;
    localparam int DEPTH = LW + 1;
    localparam int IW    = $clog2(DEPTH);
    localparam logic [PW-1:0] LAST_POS  = PW'(LEAVES - 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(NODES - 1);
    localparam logic [CW-1:0] LEAVES_C  = CW'(LEAVES);

    typedef enum logic [10:0] {
        ST_CLEAR = 11'b00000000001,
        ST_IDLE  = 11'b00000000010,
        ST_NODE  = 11'b00000000100,
        ST_QRD   = 11'b00000001000,
        ST_PRD   = 11'b00000010000,
        ST_ARD   = 11'b00000100000,
        ST_AHI   = 11'b00001000000,
        ST_AWR   = 11'b00010000000,
        ST_CHILD = 11'b00100000000,
        ST_RET   = 11'b01000000000,
        ST_FIN   = 11'b10000000000
    } state_t;

    typedef struct packed {
        logic [AW-1:0]    node;
        logic [PW-1:0]    l;
        logic [PW-1:0]    r;
        phase_t           ph;
        logic [SUM_W-1:0] sl;
        logic [SUM_W-1:0] sr;
    } frame_t;

    state_t           state_reg, state_next;
    logic [AW-1:0]    clr_addr_reg, clr_addr_next;
    logic [CNT_W-1:0] count_reg;
    logic [1:0]       kind_reg, kind_next;
    logic [PW-1:0]    ql_reg, ql_next, qr_reg, qr_next;
    logic [VAL_W-1:0] val_reg, val_next;
    logic             err_reg, err_next;
    logic [AW-1:0]    cur_node_reg, cur_node_next;
    logic [PW-1:0]    cur_l_reg, cur_l_next, cur_r_reg, cur_r_next;
    phase_t           cur_ph_reg, cur_ph_next;
    logic [SUM_W-1:0] cur_sl_reg, cur_sl_next, cur_sr_reg, cur_sr_next;
    logic [IW-1:0]    sp_reg, sp_next;
    logic             tag_fa_reg, tag_fa_next;
    logic [VAL_W-1:0] tag_va_reg, tag_va_next;
    logic [SUM_W-1:0] tag_aa_reg, tag_aa_next;
    logic [AW-1:0]    tgt_reg, tgt_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [SUM_W-1:0] acc_reg, acc_next, ret_reg, ret_next;
    logic             out_valid_reg, out_valid_next;
    logic [SUM_W-1:0] out_sum_reg, out_sum_next;
    logic             out_status_reg, out_status_next;

    frame_t stk [DEPTH];
    frame_t push_frame, top_frame;
    logic   push_en;

    logic       mem_rd_en, mem_wr_en;
    logic [AW-1:0] mem_rd_addr, mem_wr_addr;
    node_rec_t  mem_wr_data, node_q, applied;
    mul_ctl_t   mul_ctl;
    logic [SUM_W-1:0] mul_op, mul_prod;

    logic [PW:0]      mid_wide;
    logic [PW-1:0]    mid;
    logic [AW:0]      node2;
    logic [AW-1:0]    child_a, child_b;
    logic [LEN_W-1:0] len_cur, len_a, len_b;
    logic             covered, a_hit, b_hit;
    logic [CW-1:0]    limit, count_ext;
    logic             bad_req, out_free;
    logic [SUM_W-1:0] val_sext;

    lrs_node_mem #(.DEPTH(NODES), .AW(AW)) u_mem (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_data (node_q)
    );

    lrs_tag_mul #(.LEN_W(LEN_W)) u_mul (
        .clk  (clk),
        .ctl  (mul_ctl),
        .op   (mul_op),
        .len  (len_reg),
        .prod (mul_prod)
    );

    // node geometry
    assign mid_wide = ({1'b0, cur_l_reg} + {1'b0, cur_r_reg}) >> 1;
    assign mid      = mid_wide[PW-1:0];
    assign node2    = {cur_node_reg, 1'b0};
    assign child_a  = AW'(node2 + (AW+1)'(1));
    assign child_b  = AW'(node2 + (AW+1)'(2));
    assign len_cur  = LEN_W'({1'b0, cur_r_reg} - {1'b0, cur_l_reg} + (PW+1)'(1));
    assign len_a    = LEN_W'({1'b0, mid} - {1'b0, cur_l_reg} + (PW+1)'(1));
    assign len_b    = LEN_W'({1'b0, cur_r_reg} - {1'b0, mid});
    assign covered  = (ql_reg <= cur_l_reg) && (qr_reg >= cur_r_reg);
    assign a_hit    = (ql_reg <= mid) && (qr_reg >= cur_l_reg);
    assign b_hit    = (ql_reg <= cur_r_reg) && (qr_reg > mid);

    assign count_ext = CW'(count_reg);
    assign limit     = (count_ext < LEAVES_C) ? count_ext : LEAVES_C;
    assign bad_req   = (req.req_type != REQ_QUERY && req.req_type != REQ_ADD &&
                        req.req_type != REQ_ASSIGN) ||
                       (req.range_low > req.range_high) ||
                       (CW'(req.range_high) >= limit);
    assign val_sext  = {{(SUM_W-VAL_W){val_reg[VAL_W-1]}}, val_reg};
    assign out_free  = !out_valid_reg || res.ready;

    assign req.ready     = (state_reg == ST_IDLE);
    assign res.valid     = out_valid_reg;
    assign res.range_sum = out_sum_reg;
    assign res.status    = out_status_reg;

    assign top_frame = stk[sp_reg - IW'(1)];

    // assign tag and add tag fold into one multiplicand
    assign mul_op = tag_fa_reg ?
        ({{(SUM_W-VAL_W){tag_va_reg[VAL_W-1]}}, tag_va_reg} + tag_aa_reg) : tag_aa_reg;

    always_comb
    begin
        applied.sum  = (tag_fa_reg ? '0 : node_q.sum) + mul_prod;
        applied.add  = (tag_fa_reg ? '0 : node_q.add) + tag_aa_reg;
        applied.asg  = tag_fa_reg ? tag_va_reg : node_q.asg;
        applied.flag = tag_fa_reg | node_q.flag;
    end

    always_comb
    begin
        mem_rd_en   = 1'b0;
        mem_rd_addr = cur_node_reg;
        mem_wr_en   = 1'b0;
        mem_wr_addr = tgt_reg;
        mem_wr_data = applied;
        mul_ctl     = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = clr_addr_reg;
                mem_wr_data = '0;
            end
            ST_NODE:
            begin
                mem_rd_en = 1'b1;
            end
            ST_ARD:
            begin
                mem_rd_en    = 1'b1;
                mem_rd_addr  = tgt_reg;
                mul_ctl.lo_en = 1'b1;
            end
            ST_AHI:
            begin
                mul_ctl.hi_en = 1'b1;
            end
            ST_AWR:
            begin
                mem_wr_en = 1'b1;
            end
            ST_CHILD:
            begin
                if (cur_ph_reg == PH_DONE)
                begin
                    mem_wr_en       = 1'b1;
                    mem_wr_addr     = cur_node_reg;
                    mem_wr_data     = '0;
                    mem_wr_data.sum = cur_sl_reg + cur_sr_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        kind_next       = kind_reg;
        ql_next         = ql_reg;
        qr_next         = qr_reg;
        val_next        = val_reg;
        err_next        = err_reg;
        cur_node_next   = cur_node_reg;
        cur_l_next      = cur_l_reg;
        cur_r_next      = cur_r_reg;
        cur_ph_next     = cur_ph_reg;
        cur_sl_next     = cur_sl_reg;
        cur_sr_next     = cur_sr_reg;
        sp_next         = sp_reg;
        tag_fa_next     = tag_fa_reg;
        tag_va_next     = tag_va_reg;
        tag_aa_next     = tag_aa_reg;
        tgt_next        = tgt_reg;
        len_next        = len_reg;
        acc_next        = acc_reg;
        ret_next        = ret_reg;
        out_valid_next  = out_valid_reg && !res.ready;
        out_sum_next    = out_sum_reg;
        out_status_next = out_status_reg;
        push_en         = 1'b0;
        push_frame      = '{node: cur_node_reg, l: cur_l_reg, r: cur_r_reg,
                            ph: cur_ph_reg, sl: cur_sl_reg, sr: cur_sr_reg};
        case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    kind_next     = req.req_type;
                    ql_next       = PW'(req.range_low);
                    qr_next       = PW'(req.range_high);
                    val_next      = req.value;
                    err_next      = bad_req;
                    acc_next      = '0;
                    sp_next       = '0;
                    cur_node_next = '0;
                    cur_l_next    = '0;
                    cur_r_next    = LAST_POS;
                    state_next    = bad_req ? ST_FIN : ST_NODE;
                end
            end
            ST_NODE:
            begin
                if (covered)
                begin
                    if (kind_reg == REQ_QUERY)
                    begin
                        state_next = ST_QRD;
                    end
                    else
                    begin
                        tag_fa_next = (kind_reg == REQ_ASSIGN);
                        tag_va_next = val_reg;
                        tag_aa_next = (kind_reg == REQ_ADD) ? val_sext : '0;
                        tgt_next    = cur_node_reg;
                        len_next    = len_cur;
                        cur_ph_next = PH_COVER;
                        state_next  = ST_ARD;
                    end
                end
                else
                begin
                    state_next = ST_PRD;
                end
            end
            ST_QRD:
            begin
                // the parent rebuilds its sum from the full child sum
                acc_next   = acc_reg + node_q.sum;
                ret_next   = node_q.sum;
                state_next = ST_RET;
            end
            ST_PRD:
            begin
                // split node: its tags go down into both children
                tag_fa_next = node_q.flag;
                tag_va_next = node_q.asg;
                tag_aa_next = node_q.add;
                tgt_next    = child_a;
                len_next    = len_a;
                cur_ph_next = PH_PUSH_A;
                state_next  = ST_ARD;
            end
            ST_ARD:
            begin
                state_next = ST_AHI;
            end
            ST_AHI:
            begin
                state_next = ST_AWR;
            end
            ST_AWR:
            begin
                case (cur_ph_reg)
                    PH_PUSH_A:
                    begin
                        cur_sl_next = applied.sum;
                        tgt_next    = child_b;
                        len_next    = len_b;
                        cur_ph_next = PH_PUSH_B;
                        state_next  = ST_ARD;
                    end
                    PH_PUSH_B:
                    begin
                        cur_sr_next = applied.sum;
                        cur_ph_next = PH_CHILD_A;
                        state_next  = ST_CHILD;
                    end
                    default:
                    begin
                        ret_next   = applied.sum;
                        state_next = ST_RET;
                    end
                endcase
            end
            ST_CHILD:
            begin
                case (cur_ph_reg)
                    PH_CHILD_A:
                    begin
                        if (a_hit)
                        begin
                            push_en       = 1'b1;
                            push_frame.ph = PH_CHILD_B;
                            sp_next       = sp_reg + IW'(1);
                            cur_node_next = child_a;
                            cur_r_next    = mid;
                            state_next    = ST_NODE;
                        end
                        else
                        begin
                            cur_ph_next = PH_CHILD_B;
                        end
                    end
                    PH_CHILD_B:
                    begin
                        if (b_hit)
                        begin
                            push_en       = 1'b1;
                            push_frame.ph = PH_DONE;
                            sp_next       = sp_reg + IW'(1);
                            cur_node_next = child_b;
                            cur_l_next    = mid + PW'(1);
                            state_next    = ST_NODE;
                        end
                        else
                        begin
                            cur_ph_next = PH_DONE;
                        end
                    end
                    default:
                    begin
                        ret_next   = cur_sl_reg + cur_sr_reg;
                        state_next = ST_RET;
                    end
                endcase
            end
            ST_RET:
            begin
                if (sp_reg == '0)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    cur_node_next = top_frame.node;
                    cur_l_next    = top_frame.l;
                    cur_r_next    = top_frame.r;
                    cur_ph_next   = top_frame.ph;
                    cur_sl_next   = top_frame.sl;
                    cur_sr_next   = top_frame.sr;
                    if (top_frame.ph == PH_CHILD_B)
                    begin
                        cur_sl_next = ret_reg;
                    end
                    else
                    begin
                        cur_sr_next = ret_reg;
                    end
                    sp_next    = sp_reg - IW'(1);
                    state_next = ST_CHILD;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_sum_next    = (err_reg || kind_reg != REQ_QUERY) ? '0 : acc_reg;
                    out_status_next = err_reg ? STATUS_ERR : STATUS_OK;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            count_reg     <= ELEMENT_COUNT_RESET;
            sp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            sp_reg        <= sp_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                count_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        ql_reg         <= ql_next;
        qr_reg         <= qr_next;
        val_reg        <= val_next;
        err_reg        <= err_next;
        cur_node_reg   <= cur_node_next;
        cur_l_reg      <= cur_l_next;
        cur_r_reg      <= cur_r_next;
        cur_ph_reg     <= cur_ph_next;
        cur_sl_reg     <= cur_sl_next;
        cur_sr_reg     <= cur_sr_next;
        tag_fa_reg     <= tag_fa_next;
        tag_va_reg     <= tag_va_next;
        tag_aa_reg     <= tag_aa_next;
        tgt_reg        <= tgt_next;
        len_reg        <= len_next;
        acc_reg        <= acc_next;
        ret_reg        <= ret_next;
        out_sum_reg    <= out_sum_next;
        out_status_reg <= out_status_next;
        if (push_en)
        begin
            stk[sp_reg] <= push_frame;
        end
    end

endmodule

/* hdl/lrs_node_mem.sv */
// lrs_node_mem: single read, single write node memory, registered read data
// depends on lrs_pkg for the node record type
module lrs_node_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  lrs_pkg::node_rec_t wr_data,
    output lrs_pkg::node_rec_t rd_data
);
    import lrs_pkg::*;

    node_rec_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* hdl/lrs_tag_mul.sv */
// lrs_tag_mul: 64-bit tag value times segment length, two 32-bit halves
// in turn, lower half first, both registered; depends on lrs_pkg
module lrs_tag_mul #(
    parameter int LEN_W = 11
) (
    input  logic                     clk,
    input  lrs_pkg::mul_ctl_t        ctl,
    input  logic [lrs_pkg::SUM_W-1:0] op,
    input  logic [LEN_W-1:0]         len,
    output logic [lrs_pkg::SUM_W-1:0] prod
);
    import lrs_pkg::*;

    localparam int PW = 32 + LEN_W;

    logic [PW-1:0]    lo_reg;
    logic [PW-1:0]    lo_full;
    logic [PW-1:0]    hi_full;
    logic [SUM_W-1:0] prod_reg;

    assign lo_full = op[31:0] * len;
    assign hi_full = op[63:32] * len;
    assign prod    = prod_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.lo_en)
        begin
            lo_reg <= lo_full;
        end
        if (ctl.hi_en)
        begin
            // only the low half of the upper partial product survives mod 2^64
            prod_reg <= SUM_W'(lo_reg) + {hi_full[31:0], 32'd0};
        end
    end

endmodule

/* hdl/lrs_checker.sv */
// lrs_checker: port-level assertions for the range tree, bound to the top
// depends on lrs_pkg and the top level lazy_range_add_assign_sum_tree
module lrs_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      req_valid,
    input logic                      req_ready,
    input logic                      res_valid,
    input logic                      res_ready,
    input logic [lrs_pkg::SUM_W-1:0] res_sum,
    input logic                      res_status
);
    import lrs_pkg::*;

    logic [1:0] open_reg;
    logic       in_acc, out_acc;

    assign in_acc  = req_valid && req_ready;
    assign out_acc = res_valid && res_ready;

    // transactions taken in but not yet answered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= '0;
        end
        else
        begin
            open_reg <= open_reg + 2'(in_acc) - 2'(out_acc);
        end
    end

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_sum) && $stable(res_status))
        else $error("result changed while stalled");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_status == STATUS_ERR |-> res_sum == '0)
        else $error("rejected transaction carries a non-zero sum");

    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> open_reg != 2'd0)
        else $error("result without a pending request");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !req_ready)
        else $error("request taken while previous one still in work");

endmodule

bind lazy_range_add_assign_sum_tree lrs_checker u_lrs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .res_valid  (res.valid),
    .res_ready  (res.ready),
    .res_sum    (res.range_sum),
    .res_status (res.status)
);
